/* sv/lmbas_pkg.sv */
// Shared constants, types and pin map of the LED matrix bit angle scanner.
package lmbas_pkg;

    localparam int ROW_COUNT     = 2;
    localparam int BYTES_PER_ROW = 24;
    localparam int STORE_SIZE    = ROW_COUNT * BYTES_PER_ROW;
    localparam int BYTE_W        = 8;
    localparam int ADDR_W        = 6;
    localparam int ROW_W         = 1;
    localparam int SEL_W         = 5;
    localparam int NUM_PORTS     = 3;
    localparam int PORT_SEL_W    = 2;
    localparam int PIN_BIT_W     = 3;
    localparam int LINE_W        = 2;

    localparam logic [BYTE_W-1:0] MASK_TOP = 8'h80;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [BYTES_PER_ROW-1:0][BYTE_W-1:0] t_row_data;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [SEL_W-1:0] sel;
        t_byte            data;
    } t_wr_req;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
    } t_rd_req;

    // channel -> output port (0 = one, 1 = two, 2 = three)
    localparam logic [PORT_SEL_W-1:0] PIN_PORT [BYTES_PER_ROW] = '{
        2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2
    };

    // channel -> bit position within its port
    localparam logic [PIN_BIT_W-1:0] PIN_BIT [BYTES_PER_ROW] = '{
        3'd6, 3'd5, 3'd4, 3'd6, 3'd7, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
        3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd0, 3'd3, 3'd4, 3'd5
    };

endpackage

/* sv/lmbas_if.sv */
// Valid/ready channel interfaces for input words and result words.
interface lmbas_item_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [lmbas_pkg::ADDR_W-1:0]  address;
    logic [lmbas_pkg::BYTE_W-1:0]  value;

    modport source (output valid, kind, address, value, input ready);
    modport sink   (input valid, kind, address, value, output ready);
endinterface

interface lmbas_result_if;
    logic                          valid;
    logic                          ready;
    logic [lmbas_pkg::BYTE_W-1:0]  port_a;
    logic [lmbas_pkg::BYTE_W-1:0]  port_b;
    logic [lmbas_pkg::BYTE_W-1:0]  port_c;
    logic [lmbas_pkg::LINE_W-1:0]  line_enable;
    logic                          plane_loaded;

    modport source (output valid, port_a, port_b, port_c, line_enable, plane_loaded,
                    input ready);
    modport sink   (input valid, port_a, port_b, port_c, line_enable, plane_loaded,
                    output ready);
endinterface

/* sv/lmbas_frame_store.sv */
// Frame store: row-wide memory with byte writes, per-byte valid bits, registered row read.
module lmbas_frame_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lmbas_pkg::t_wr_req   i_wr,
    input  lmbas_pkg::t_rd_req   i_rd,
    output lmbas_pkg::t_row_data o_row
);
    import lmbas_pkg::*;

    t_row_data                r_mem [ROW_COUNT];
    logic [BYTES_PER_ROW-1:0] r_valid [ROW_COUNT];
    t_row_data                r_rd_data;
    logic [BYTES_PER_ROW-1:0] r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            for (int b = 0; b < BYTES_PER_ROW; b++) begin
                if (i_wr.sel == SEL_W'(b)) begin
                    r_mem[i_wr.row][b] <= i_wr.data;
                end
            end
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.row];
        end
    end

    // unwritten bytes read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_valid[r] <= '0;
            end
            r_rd_vld <= '0;
        end else begin
            if (i_wr.en) begin
                for (int b = 0; b < BYTES_PER_ROW; b++) begin
                    if (i_wr.sel == SEL_W'(b)) begin
                        r_valid[i_wr.row][b] <= 1'b1;
                    end
                end
            end
            if (i_rd.en) begin
                r_rd_vld <= r_valid[i_rd.row];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < BYTES_PER_ROW; b++) begin
            o_row[b] = r_rd_vld[b] ? r_rd_data[b] : '0;
        end
    end

endmodule

/* sv/led_matrix_bit_angle_scanner.sv */
// Top level of the LED matrix bit angle scanner (binary code modulation driver).
//
//  channel    dir  words              handshake
//  i_item     in   kind/address/value valid & ready
//  o_result   out  ports/line/loaded  valid & ready
//
//  One word per cycle sustained while o_result is ready; each accepted word goes through
//  the frame store row read, then the pin scatter into the output register.
//  Reset (i_rst_n low, synchronous) clears the frame store valid bits, counters and latches.
//  A stalled result holds the scatter stage; input is still taken while the scatter
//  stage is empty or advancing.
module led_matrix_bit_angle_scanner (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lmbas_item_if.sink            i_item,
    lmbas_result_if.source        o_result
);
    import lmbas_pkg::*;

    logic                 accept;
    logic                 out_free;
    logic                 is_tick;
    logic [BYTE_W-1:0]    cnt_inc;
    logic                 tick_hit;
    logic [BYTE_W-1:0]    mask_sh;
    logic                 mask_wrap;
    logic [BYTE_W-1:0]    n_plane_mask;
    logic [ROW_W-1:0]     n_row;
    logic                 wr_in_range;
    logic                 wr_hi_row;
    t_wr_req              wr_req;
    t_rd_req              rd_req;
    t_row_data            row_data;
    logic [NUM_PORTS-1:0][BYTE_W-1:0] scatter;

    logic [BYTE_W-1:0]    r_tick_count;
    logic [BYTE_W-1:0]    r_plane_mask;
    logic [ROW_W-1:0]     r_row;
    logic                 r_s1_valid;
    logic                 r_s1_load;
    logic [BYTE_W-1:0]    r_s1_mask;
    logic [ROW_W-1:0]     r_s1_row;
    logic                 r_out_valid;
    logic                 r_loaded;
    logic [NUM_PORTS-1:0][BYTE_W-1:0] r_pins;
    logic [LINE_W-1:0]    r_line;

    assign out_free     = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_s1_valid || out_free;
    assign accept       = i_item.valid && i_item.ready;
    assign is_tick      = (i_item.kind == KIND_TICK);

    // tick counter and plane sequencing; interval always equals the plane mask
    assign cnt_inc      = r_tick_count + BYTE_W'(1);
    assign tick_hit     = is_tick && (cnt_inc >= r_plane_mask);
    assign mask_sh      = r_plane_mask >> 1;
    assign mask_wrap    = (mask_sh == '0);
    assign n_plane_mask = mask_wrap ? MASK_TOP : mask_sh;

    always_comb begin
        n_row = r_row;
        if (mask_wrap) begin
            n_row = (r_row == ROW_W'(ROW_COUNT - 1)) ? '0 : r_row + ROW_W'(1);
        end
    end

    // frame store access
    assign wr_in_range = (i_item.address < ADDR_W'(STORE_SIZE));
    assign wr_hi_row   = (i_item.address >= ADDR_W'(BYTES_PER_ROW));

    always_comb begin
        wr_req.en   = accept && (i_item.kind == KIND_WRITE) && wr_in_range;
        wr_req.row  = ROW_W'(wr_hi_row);
        wr_req.sel  = wr_hi_row ? SEL_W'(i_item.address - ADDR_W'(BYTES_PER_ROW))
                                : SEL_W'(i_item.address);
        wr_req.data = i_item.value;
        rd_req.en   = accept && tick_hit;
        rd_req.row  = n_row;
    end

    lmbas_frame_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr_req),
        .i_rd    (rd_req),
        .o_row   (row_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_plane_mask <= MASK_TOP;
            r_row        <= '0;
        end else if (accept && is_tick) begin
            r_tick_count <= tick_hit ? '0 : cnt_inc;
            if (tick_hit) begin
                r_plane_mask <= n_plane_mask;
                r_row        <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_load <= tick_hit;
            r_s1_mask <= n_plane_mask;
            r_s1_row  <= n_row;
        end
    end

    // bit plane scatter onto the pin map
    always_comb begin
        scatter = '0;
        for (int ch = 0; ch < BYTES_PER_ROW; ch++) begin
            if ((row_data[ch] & r_s1_mask) != '0) begin
                scatter[PIN_PORT[ch]][PIN_BIT[ch]] = 1'b1;
            end
        end
    end

    // output register doubles as the pin and row enable latches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_loaded    <= 1'b0;
            r_pins      <= '0;
            r_line      <= '0;
        end else if (r_s1_valid && out_free) begin
            r_out_valid <= 1'b1;
            r_loaded    <= r_s1_load;
            if (r_s1_load) begin
                r_pins <= scatter;
                r_line <= LINE_W'(1) << r_s1_row;
            end
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.port_a       = r_pins[0];
    assign o_result.port_b       = r_pins[1];
    assign o_result.port_c       = r_pins[2];
    assign o_result.line_enable  = r_line;
    assign o_result.plane_loaded = r_loaded;

endmodule
